[rtl/core/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared widths, types, codes and arithmetic helpers of the stereo feedback
// delay core.
// ----------------------------------------------------------------------------
package sfd_pkg;

    localparam int ADDR_W     = 16;
    localparam int SAMPLE_W   = 24;
    localparam int FRAC_W     = 8;
    localparam int GAIN_W     = 16;
    localparam int GAIN_FRAC  = 14;
    localparam int DELAY_W    = ADDR_W + FRAC_W;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = DELAY_W;
    localparam int MUL_A_W    = SAMPLE_W + 1;
    localparam int MUL_B_W    = GAIN_W + 1;
    localparam int PROD_W     = MUL_A_W + MUL_B_W;

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic signed [PROD_W-1:0]   t_prod;

    localparam t_prod ROUND_F = t_prod'(1) <<< (FRAC_W - 1);
    localparam t_prod ROUND_G = t_prod'(1) <<< (GAIN_FRAC - 1);
    localparam t_prod SAT_MAX = (t_prod'(1) <<< (SAMPLE_W - 1)) - t_prod'(1);
    localparam t_prod SAT_MIN = -SAT_MAX - t_prod'(1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DELAY    = 2'd0,
        CFG_MIX      = 2'd1,
        CFG_FEEDBACK = 2'd2,
        CFG_STEREO   = 2'd3
    } t_cfg_idx;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RD1,
        S_RD2,
        S_CAP,
        S_MUL_I,
        S_INTERP,
        S_MUL_F,
        S_WR_FB,
        S_MIX,
        S_DONE
    } t_state;

    // Adds a rounded Q2.14 gain product to a sample and saturates the sum.
    function automatic t_sample gain_add_sat(t_sample x, t_prod p);
        t_prod rnd;
        t_prod sum;
        rnd = (p + ROUND_G) >>> GAIN_FRAC;
        sum = t_prod'(x) + rnd;
        if (sum > SAT_MAX) begin
            return SAT_MAX[SAMPLE_W-1:0];
        end else if (sum < SAT_MIN) begin
            return SAT_MIN[SAMPLE_W-1:0];
        end
        return sum[SAMPLE_W-1:0];
    endfunction

endpackage

[rtl/core/sfd_in_if.sv]
// ----------------------------------------------------------------------------
// sfd_in_if
// Input channel carrying one stereo sample pair per transaction.
// ----------------------------------------------------------------------------
interface sfd_in_if import sfd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample left_in;
    t_sample right_in;

    modport source (output valid, output left_in, output right_in, input ready);
    modport sink   (input valid, input left_in, input right_in, output ready);
endinterface

[rtl/core/sfd_out_if.sv]
// ----------------------------------------------------------------------------
// sfd_out_if
// Output channel carrying one processed stereo sample pair per transaction.
// ----------------------------------------------------------------------------
interface sfd_out_if import sfd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_sample left_out;
    t_sample right_out;

    modport source (output valid, output left_out, output right_out, input ready);
    modport sink   (input valid, input left_out, input right_out, output ready);
endinterface

[rtl/core/sfd_ram.sv]
// ----------------------------------------------------------------------------
// sfd_ram
// Simple dual-port RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sfd_ram #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 24
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/core/sfd_mul.sv]
// ----------------------------------------------------------------------------
// sfd_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module sfd_mul import sfd_pkg::*; (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic signed [MUL_A_W-1:0] i_a,
    input  logic signed [MUL_B_W-1:0] i_b,
    output t_prod                     o_prod
);

    t_prod r_prod;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= t_prod'(i_a) * t_prod'(i_b);
        end
    end

    assign o_prod = r_prod;

endmodule

[rtl/core/stereo_feedback_delay_core.sv]
// ----------------------------------------------------------------------------
// stereo_feedback_delay_core
// Stereo feedback delay line with linearly interpolated fractional delay.
// ----------------------------------------------------------------------------
// After reset the core writes zero to every address of both delay stores and
// accepts no sample pair in that time; configuration writes are taken
// throughout. Items are then processed one at a time by a small sequencer
// around a single shared multiplier, which keeps the input closed until the
// item is through: a stereo item goes through the store reads (S_RD1, S_RD2,
// S_CAP), 5 multiplier steps per channel and the hand-over in S_DONE, and a
// mono item does the same for the left channel only. When the integer read
// position equals the write position the item skips these steps and passes
// through unchanged. A finished result waits in an output register, so a stall
// on the output side holds the core only once the next result is ready.
// ----------------------------------------------------------------------------
module stereo_feedback_delay_core import sfd_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    sfd_in_if.sink                i_in,
    sfd_out_if.source             o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_state r_state, n_state;

    logic                r_ch;
    logic [ADDR_W-1:0]   r_clr;
    logic [ADDR_W-1:0]   r_wp;
    logic [DELAY_W-1:0]  r_delay;
    logic signed [GAIN_W-1:0] r_mg;
    logic signed [GAIN_W-1:0] r_fg;
    logic                r_stereo;
    logic                r_out_valid;

    t_sample             r_in_l, r_in_r;
    t_sample             r_res_l, r_res_r;
    t_sample             r_d1_l, r_d1_r, r_d2_l, r_d2_r;
    t_sample             r_interp;
    t_sample             r_out_l, r_out_r;
    logic [ADDR_W-1:0]   r_rd, r_nx;
    logic [FRAC_W-1:0]   r_frac;

    logic [DELAY_W-1:0]  rp;
    logic [ADDR_W-1:0]   rd_now;
    logic                accept;
    logic                out_load;
    logic                we_l, we_r;
    logic [ADDR_W-1:0]   waddr, raddr;
    t_sample             wdata;
    t_sample             rdata_l, rdata_r;
    logic                mul_en;
    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    t_prod               prod;
    t_sample             d1, d2, in_ch, gained;
    logic signed [MUL_A_W-1:0] diff;
    t_prod               interp_full;

    assign rp     = {r_wp, {FRAC_W{1'b0}}} - r_delay;
    assign rd_now = rp[DELAY_W-1:FRAC_W];
    assign accept = i_in.valid && i_in.ready;

    assign d1          = r_ch ? r_d1_r : r_d1_l;
    assign d2          = r_ch ? r_d2_r : r_d2_l;
    assign in_ch       = r_ch ? r_in_r : r_in_l;
    assign diff        = MUL_A_W'(d2) - MUL_A_W'(d1);
    assign interp_full = ((t_prod'(d1) <<< FRAC_W) + prod + ROUND_F) >>> FRAC_W;
    assign gained      = gain_add_sat(in_ch, prod);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        i_in.ready = 1'b0;
        out_load   = 1'b0;
        we_l       = 1'b0;
        we_r       = 1'b0;
        waddr      = r_wp;
        wdata      = gained;
        raddr      = r_rd;
        mul_en     = 1'b0;
        mul_a      = MUL_A_W'(r_interp);
        mul_b      = MUL_B_W'(r_mg);
        case (r_state)
            S_CLEAR: begin
                we_l  = 1'b1;
                we_r  = 1'b1;
                waddr = r_clr;
                wdata = '0;
                if (r_clr == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                i_in.ready = 1'b1;
                if (i_in.valid) begin
                    n_state = (rd_now == r_wp) ? S_DONE : S_RD1;
                end
            end
            S_RD1: begin
                raddr   = r_rd;
                n_state = S_RD2;
            end
            S_RD2: begin
                raddr   = r_nx;
                n_state = S_CAP;
            end
            S_CAP: begin
                n_state = S_MUL_I;
            end
            S_MUL_I: begin
                mul_en  = 1'b1;
                mul_a   = diff;
                mul_b   = $signed(MUL_B_W'(r_frac));
                n_state = S_INTERP;
            end
            S_INTERP: begin
                n_state = S_MUL_F;
            end
            S_MUL_F: begin
                mul_en  = 1'b1;
                mul_b   = MUL_B_W'(r_fg);
                n_state = S_WR_FB;
            end
            S_WR_FB: begin
                we_l    = !r_ch;
                we_r    = r_ch;
                mul_en  = 1'b1;
                mul_b   = MUL_B_W'(r_mg);
                n_state = S_MIX;
            end
            S_MIX: begin
                n_state = (!r_ch && r_stereo) ? S_MUL_I : S_DONE;
            end
            S_DONE: begin
                out_load = !r_out_valid || o_out.ready;
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ch        <= 1'b0;
            r_clr       <= '0;
            r_wp        <= '0;
            r_delay     <= '0;
            r_mg        <= '0;
            r_fg        <= '0;
            r_stereo    <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + 1'b1;
            end
            if (i_cfg_we) begin
                case (t_cfg_idx'(i_cfg_idx))
                    CFG_DELAY:    r_delay  <= i_cfg_wdata[DELAY_W-1:0];
                    CFG_MIX:      r_mg     <= i_cfg_wdata[GAIN_W-1:0];
                    CFG_FEEDBACK: r_fg     <= i_cfg_wdata[GAIN_W-1:0];
                    CFG_STEREO:   r_stereo <= i_cfg_wdata[0];
                    default: ;
                endcase
            end
            if (accept) begin
                r_ch <= 1'b0;
            end else if (r_state == S_MIX && !r_ch && r_stereo) begin
                r_ch <= 1'b1;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
                r_wp        <= r_wp + 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_l  <= i_in.left_in;
            r_in_r  <= i_in.right_in;
            r_res_l <= i_in.left_in;
            r_res_r <= i_in.right_in;
            r_rd    <= rd_now;
            r_nx    <= rd_now + 1'b1;
            r_frac  <= rp[FRAC_W-1:0];
        end
        if (r_state == S_RD2) begin
            r_d1_l <= rdata_l;
            r_d1_r <= rdata_r;
        end
        if (r_state == S_CAP) begin
            r_d2_l <= rdata_l;
            r_d2_r <= rdata_r;
        end
        if (r_state == S_INTERP) begin
            r_interp <= interp_full[SAMPLE_W-1:0];
        end
        if (r_state == S_MIX) begin
            if (r_ch) begin
                r_res_r <= gained;
            end else begin
                r_res_l <= gained;
            end
        end
        if (out_load) begin
            r_out_l <= r_res_l;
            r_out_r <= r_res_r;
        end
    end

    sfd_mul u_mul (
        .i_clk  (i_clk),
        .i_en   (mul_en),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    sfd_ram #(.ADDR_W(ADDR_W), .DATA_W(SAMPLE_W)) u_ram_l (
        .i_clk   (i_clk),
        .i_we    (we_l),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_l)
    );

    sfd_ram #(.ADDR_W(ADDR_W), .DATA_W(SAMPLE_W)) u_ram_r (
        .i_clk   (i_clk),
        .i_we    (we_r),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata_r)
    );

    assign o_out.valid     = r_out_valid;
    assign o_out.left_out  = r_out_l;
    assign o_out.right_out = r_out_r;

endmodule

[rtl/core/sfd_checker.sv]
// ----------------------------------------------------------------------------
// sfd_checker
// Port-level checks of the stereo feedback delay core, bound to the top level.
// ----------------------------------------------------------------------------
module sfd_checker import sfd_pkg::*; (
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    i_in_valid,
    input logic    i_in_ready,
    input logic    i_out_valid,
    input logic    i_out_ready,
    input t_sample i_left_out,
    input t_sample i_right_out
);

    // The core works on one transaction at a time.
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("input accepted again while a transaction is in progress");

    // A new result appears only as the core returns to waiting for input.
    a_result_with_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> i_in_ready)
        else $error("result appeared while the core was still busy");

    // Reset empties the output and starts the store clearing pass.
    a_reset_state: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("core not quiet after reset");

    // A stalled result holds its value.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_left_out) && $stable(i_right_out))
        else $error("stalled result changed");

endmodule

bind stereo_feedback_delay_core sfd_checker u_sfd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in.valid),
    .i_in_ready  (i_in.ready),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_left_out  (o_out.left_out),
    .i_right_out (o_out.right_out)
);
